// ===== rtl/core/cfr2_pkg.sv =====
// Shared constants and twiddle generation for the radix-2 FFT block.
// No dependencies; imported by the front, queue, back, top level and checker.
package cfr2_pkg;

    localparam int MAX_LOG2_POINTS_DEF = 6;
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int LOG2_REG_W          = 3;
    localparam logic [LOG2_REG_W-1:0] LOG2_RESET = 3'd6;
    localparam int TW_W                = 16;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // unsigned quotient by shift and subtract, for elaboration-time tables
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        begin
            q   = '0;
            rem = '0;
            for (int i = 63; i >= 0; i--) begin
                rem = {rem[62:0], num[i]};
                if (rem >= den) begin
                    rem  = rem - den;
                    q[i] = 1'b1;
                end
            end
            return q;
        end
    endfunction

    // sin(pi*idx/(2*pts)) in Q1.15 with pts = 2**lg, rounded to nearest, ties up,
    // clipped at 32767
    function automatic logic [TW_W-1:0] qsin_calc(input int unsigned idx,
                                                  input int unsigned lg);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          r;
        begin
            x    = (PI_Q30 * longint'(idx) + (64'd1 << lg)) >> (lg + 1);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 12; n++) begin
                term = udiv((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1) sum = sum - longint'(term);
                else              sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            r = (sum + 16384) >>> 15;
            if (r > 32767) r = 32767;
            return TW_W'(r);
        end
    endfunction

endpackage

// ===== rtl/core/complex_fft_radix2.sv =====
// Channel   | handshake                      | payload
// sample in | i_sample_valid/o_sample_ready  | i_sample_re, i_sample_im
// bin out   | o_bin_valid/i_bin_ready        | o_bin_re, o_bin_im, o_bin_last
// config    | i_cfg_we                       | i_cfg_wdata (log2 of length)
//
// A frame of N samples loads at one per cycle, while the queue has room, into a four-entry queue and the store.
// The transform runs each butterfly through read, multiply, sum and two write steps
// on the single shared butterfly unit, then reads and emits each bin in turn.
// Reset is synchronous; no clearing pass. Samples queue during the transform and
// input stalls once the queue fills. A register write restarts the frame count.
// Top level: configuration register, length clamp and the front/queue/back chain.
// Depends on cfr2_pkg, cfr2_front, cfr2_fifo and cfr2_back.
module complex_fft_radix2 import cfr2_pkg::*; #(
    parameter int MAX_LOG2_POINTS = MAX_LOG2_POINTS_DEF,
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [LOG2_REG_W-1:0]          i_cfg_wdata,
    input  logic                           i_sample_valid,
    output logic                           o_sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_im,
    output logic                           o_bin_valid,
    input  logic                           i_bin_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_bin_re,
    output logic signed [SAMPLE_WIDTH-1:0] o_bin_im,
    output logic                           o_bin_last
);
    localparam int LW = $clog2(MAX_LOG2_POINTS + 1);
    localparam int DW = MAX_LOG2_POINTS + 2 * SAMPLE_WIDTH + 1;
    localparam int CW = (LW > LOG2_REG_W) ? LW : LOG2_REG_W;

    logic [LOG2_REG_W-1:0] r_log2_points;
    logic [LW-1:0]         eff_log2;
    logic [CW-1:0]         cfg_wide;

    // clamp the register to 1..MAX_LOG2_POINTS
    always_comb begin
        cfg_wide = CW'(r_log2_points);
        if (cfg_wide == '0) begin
            eff_log2 = LW'(1);
        end else if (cfg_wide > CW'(MAX_LOG2_POINTS)) begin
            eff_log2 = LW'(MAX_LOG2_POINTS);
        end else begin
            eff_log2 = LW'(cfg_wide);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_points <= LOG2_RESET;
        end else if (i_cfg_we) begin
            r_log2_points <= i_cfg_wdata;
        end
    end

    logic          push, push_ready, pop, pop_valid;
    logic [DW-1:0] push_data, pop_data;

    cfr2_front #(
        .MAX_LOG2_POINTS(MAX_LOG2_POINTS), .SAMPLE_WIDTH(SAMPLE_WIDTH), .LW(LW), .DW(DW)
    ) u_front (
        .i_clk, .i_rst_n,
        .i_log2         (eff_log2),
        .i_clear        (i_cfg_we),
        .i_sample_valid, .o_sample_ready, .i_sample_re, .i_sample_im,
        .o_push         (push),
        .o_push_data    (push_data),
        .i_push_ready   (push_ready)
    );

    cfr2_fifo #(.DW(DW)) u_fifo (
        .i_clk, .i_rst_n,
        .i_push       (push),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data)
    );

    cfr2_back #(
        .MAX_LOG2_POINTS(MAX_LOG2_POINTS), .SAMPLE_WIDTH(SAMPLE_WIDTH), .LW(LW), .DW(DW)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_log2      (eff_log2),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .o_bin_valid, .i_bin_ready, .o_bin_re, .o_bin_im, .o_bin_last
    );

endmodule

// ===== rtl/core/cfr2_front.sv =====
// Input side: counts samples in the frame and computes bit-reversed store addresses.
// Depends on cfr2_pkg; feeds cfr2_fifo.
module cfr2_front import cfr2_pkg::*; #(
    parameter int MAX_LOG2_POINTS = MAX_LOG2_POINTS_DEF,
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int LW              = $clog2(MAX_LOG2_POINTS + 1),
    parameter int DW              = MAX_LOG2_POINTS + 2 * SAMPLE_WIDTH + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [LW-1:0]                  i_log2,
    input  logic                           i_clear,
    input  logic                           i_sample_valid,
    output logic                           o_sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_im,
    output logic                           o_push,
    output logic [DW-1:0]                  o_push_data,
    input  logic                           i_push_ready
);
    localparam int AW = MAX_LOG2_POINTS;

    logic [AW-1:0] r_count;
    logic [AW-1:0] n_count;
    logic [AW-1:0] rev_full;
    logic [AW-1:0] pos;
    logic [AW-1:0] last_idx;
    logic          is_last;

    // reverse across the full address width, then drop the unused low bits
    always_comb begin
        for (int b = 0; b < AW; b++) begin
            rev_full[AW-1-b] = r_count[b];
        end
        pos      = rev_full >> (AW - int'(i_log2));
        last_idx = AW'(((AW+1)'(1) << i_log2) - (AW+1)'(1));
        is_last  = (r_count == last_idx);
    end

    assign o_sample_ready = i_push_ready;
    assign o_push         = i_sample_valid & i_push_ready;
    assign o_push_data    = {pos, i_sample_re, i_sample_im, is_last};

    // advance the frame count on each transfer, restart on a register write
    always_comb begin
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (o_push) begin
            n_count = is_last ? '0 : r_count + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/core/cfr2_fifo.sv =====
// Four-entry queue between the sample front end and the transform engine.
// Depends on cfr2_pkg for the default payload width.
module cfr2_fifo import cfr2_pkg::*; #(
    parameter int DW = MAX_LOG2_POINTS_DEF + 2 * SAMPLE_WIDTH_DEF + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_push_data,
    output logic          o_push_ready,
    input  logic          i_pop,
    output logic          o_pop_valid,
    output logic [DW-1:0] o_pop_data
);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [DW-1:0] r_slot [DEPTH];
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [PW:0]   r_fill;
    logic          do_pop;

    assign o_push_ready = (r_fill != (PW+1)'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_data   = r_slot[r_head];
    assign do_pop       = i_pop & o_pop_valid;

    // hold payload in the slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_tail] <= i_push_data;
        end
    end

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_tail <= r_tail + PW'(1);
            if (do_pop) r_head <= r_head + PW'(1);
            r_fill <= r_fill + (PW+1)'(i_push) - (PW+1)'(do_pop);
        end
    end

endmodule

// ===== rtl/core/cfr2_back.sv =====
// Transform engine: data store, one shared butterfly sequencer, and bin output.
// Depends on cfr2_pkg for the twiddle function; drains cfr2_fifo.
module cfr2_back import cfr2_pkg::*; #(
    parameter int MAX_LOG2_POINTS = MAX_LOG2_POINTS_DEF,
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int LW              = $clog2(MAX_LOG2_POINTS + 1),
    parameter int DW              = MAX_LOG2_POINTS + 2 * SAMPLE_WIDTH + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [LW-1:0]                  i_log2,
    input  logic                           i_pop_valid,
    input  logic [DW-1:0]                  i_pop_data,
    output logic                           o_pop,
    output logic                           o_bin_valid,
    input  logic                           i_bin_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_bin_re,
    output logic signed [SAMPLE_WIDTH-1:0] o_bin_im,
    output logic                           o_bin_last
);
    localparam int AW = MAX_LOG2_POINTS;
    localparam int W  = SAMPLE_WIDTH;
    localparam int P  = 1 << AW;
    localparam logic signed [W+2:0] SHI = (W+3)'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [W+2:0] SLO = (W+3)'(-(64'sd1 <<< (W - 1)));

    function automatic logic [P:0][TW_W-1:0] qsin_table();
        logic [P:0][TW_W-1:0] t;
        begin
            for (int i = 0; i <= P; i++) begin
                t[i] = qsin_calc(i, AW);
            end
            return t;
        end
    endfunction

    localparam logic [P:0][TW_W-1:0] QSIN = qsin_table();

    function automatic logic signed [W-1:0] sat_w(input logic signed [W+2:0] v);
        begin
            if (v > SHI) return W'(SHI);
            if (v < SLO) return W'(SLO);
            return W'(v);
        end
    endfunction

    typedef enum logic [2:0] {
        S_LOAD, S_RD, S_MUL, S_SUM, S_WA, S_WB, S_ERD, S_EOUT
    } t_state;

    // data store
    logic signed [W-1:0] r_mem_re [P];
    logic signed [W-1:0] r_mem_im [P];
    logic signed [W-1:0] r_rd_a_re, r_rd_a_im, r_rd_b_re, r_rd_b_im;
    logic                rd_en;
    logic [AW-1:0]       rd_a_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic signed [W-1:0] wr_re, wr_im;

    // sequencer
    t_state          r_state;
    logic [LW-1:0]   r_stage;
    logic [AW-1:0]   r_bf;
    logic [AW-1:0]   r_bin;

    // datapath registers
    logic signed [TW_W-1:0] r_wr, r_ws;
    logic signed [W+15:0]   r_p1, r_p2, r_p3, r_p4;
    logic signed [W-1:0]    r_na_re, r_na_im, r_nb_re, r_nb_im;

    // address and twiddle generation
    logic [AW:0]            one_k;
    logic [AW-1:0]          mask;
    logic [AW-1:0]          a_addr;
    logic [AW-1:0]          b_addr;
    logic [AW+1:0]          tw_idx;
    logic signed [TW_W-1:0] tw_re, tw_s;
    logic [AW-1:0]          last_bf;
    logic [AW-1:0]          last_bin;
    logic                   bf_done;
    logic                   stage_done;

    // queue entry fields
    logic [AW-1:0]       q_addr;
    logic signed [W-1:0] q_re, q_im;
    logic                q_last;

    assign q_addr = i_pop_data[DW-1 -: AW];
    assign q_re   = i_pop_data[2*W:W+1];
    assign q_im   = i_pop_data[W:1];
    assign q_last = i_pop_data[0];

    // butterfly addresses: insert a zero at bit "stage" of the counter
    always_comb begin
        one_k    = (AW+1)'(1) << r_stage;
        mask     = AW'(one_k - (AW+1)'(1));
        a_addr   = AW'(((r_bf & ~mask) << 1) | (r_bf & mask));
        b_addr   = a_addr | AW'(one_k);
        tw_idx   = (AW+2)'(r_bf & mask) << (AW + 1 - int'(r_stage));
        if (tw_idx <= (AW+2)'(P)) begin
            tw_re = TW_W'(QSIN[(AW+1)'((AW+2)'(P) - tw_idx)]);
            tw_s  = TW_W'(QSIN[(AW+1)'(tw_idx)]);
        end else begin
            tw_re = -TW_W'(QSIN[(AW+1)'(tw_idx - (AW+2)'(P))]);
            tw_s  = TW_W'(QSIN[(AW+1)'((AW+2)'(2 * P) - tw_idx)]);
        end
        last_bf    = AW'(((AW+1)'(1) << i_log2) >> 1) - AW'(1);
        last_bin   = AW'(((AW+1)'(1) << i_log2) - (AW+1)'(1));
        bf_done    = (r_bf == last_bf);
        stage_done = (r_stage == i_log2 - LW'(1));
    end

    // butterfly product sums and rounding
    logic signed [W+16:0] s_re, s_im;
    logic signed [W+1:0]  t_re, t_im;
    always_comb begin
        s_re = (W+17)'(r_p1) + (W+17)'(r_p2) + (W+17)'(16384);
        s_im = (W+17)'(r_p3) - (W+17)'(r_p4) + (W+17)'(16384);
        t_re = (W+2)'(s_re >>> 15);
        t_im = (W+2)'(s_im >>> 15);
    end

    // store port control
    always_comb begin
        rd_en     = (r_state == S_RD) || (r_state == S_ERD);
        rd_a_addr = (r_state == S_ERD) ? r_bin : a_addr;
        o_pop     = (r_state == S_LOAD);
        wr_en     = 1'b0;
        wr_addr   = a_addr;
        wr_re     = r_na_re;
        wr_im     = r_na_im;
        unique case (r_state)
            S_LOAD: begin
                wr_en   = i_pop_valid;
                wr_addr = q_addr;
                wr_re   = q_re;
                wr_im   = q_im;
            end
            S_WA: wr_en = 1'b1;
            S_WB: begin
                wr_en   = 1'b1;
                wr_addr = b_addr;
                wr_re   = r_nb_re;
                wr_im   = r_nb_im;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_re[wr_addr] <= wr_re;
            r_mem_im[wr_addr] <= wr_im;
        end
        if (rd_en) begin
            r_rd_a_re <= r_mem_re[rd_a_addr];
            r_rd_a_im <= r_mem_im[rd_a_addr];
            r_rd_b_re <= r_mem_re[b_addr];
            r_rd_b_im <= r_mem_im[b_addr];
        end
    end

    // datapath: twiddle latch, products, then halved outputs
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_wr <= tw_re;
            r_ws <= tw_s;
        end
        if (r_state == S_MUL) begin
            r_p1 <= r_rd_b_re * r_wr;
            r_p2 <= r_rd_b_im * r_ws;
            r_p3 <= r_rd_b_im * r_wr;
            r_p4 <= r_rd_b_re * r_ws;
        end
        if (r_state == S_SUM) begin
            r_na_re <= sat_w(((W+3)'(r_rd_a_re) + (W+3)'(t_re)) >>> 1);
            r_na_im <= sat_w(((W+3)'(r_rd_a_im) + (W+3)'(t_im)) >>> 1);
            r_nb_re <= sat_w(((W+3)'(r_rd_a_re) - (W+3)'(t_re)) >>> 1);
            r_nb_im <= sat_w(((W+3)'(r_rd_a_im) - (W+3)'(t_im)) >>> 1);
        end
    end

    // sequencer: load, butterflies stage by stage, then emit in natural order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_stage <= '0;
            r_bf    <= '0;
            r_bin   <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_pop_valid && q_last) begin
                        r_state <= S_RD;
                        r_stage <= '0;
                        r_bf    <= '0;
                    end
                end
                S_RD:  r_state <= S_MUL;
                S_MUL: r_state <= S_SUM;
                S_SUM: r_state <= S_WA;
                S_WA:  r_state <= S_WB;
                S_WB: begin
                    if (!bf_done) begin
                        r_bf    <= r_bf + AW'(1);
                        r_state <= S_RD;
                    end else if (!stage_done) begin
                        r_bf    <= '0;
                        r_stage <= r_stage + LW'(1);
                        r_state <= S_RD;
                    end else begin
                        r_bin   <= '0;
                        r_state <= S_ERD;
                    end
                end
                S_ERD: r_state <= S_EOUT;
                S_EOUT: begin
                    if (i_bin_ready) begin
                        if (r_bin == last_bin) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_bin   <= r_bin + AW'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_bin_valid = (r_state == S_EOUT);
    assign o_bin_re    = r_rd_a_re;
    assign o_bin_im    = r_rd_a_im;
    assign o_bin_last  = (r_bin == last_bin);

endmodule

// ===== rtl/core/cfr2_checker.sv =====
// Port-level checks for the radix-2 FFT block, bound to the top level.
// Depends on cfr2_pkg and complex_fft_radix2.
module cfr2_checker import cfr2_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_bin_valid,
    input logic                    i_bin_ready,
    input logic [SAMPLE_WIDTH-1:0] o_bin_re,
    input logic [SAMPLE_WIDTH-1:0] o_bin_im,
    input logic                    o_bin_last
);
    // no bin right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_bin_valid)
        else $error("bin valid after reset");

    // a stalled bin holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bin_valid && !i_bin_ready) |=>
            (o_bin_valid && $stable(o_bin_re) && $stable(o_bin_im) && $stable(o_bin_last)))
        else $error("stalled bin changed");

    // the last bin closes the frame: output goes quiet next cycle
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bin_valid && i_bin_ready && o_bin_last) |=> !o_bin_valid)
        else $error("bin after frame end");

    // a taken bin is never followed back to back by another bin
    a_bin_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bin_valid && i_bin_ready) |=> !o_bin_valid)
        else $error("bins back to back");

endmodule

bind complex_fft_radix2 cfr2_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cfr2_checker (
    .i_clk, .i_rst_n, .o_bin_valid, .i_bin_ready, .o_bin_re, .o_bin_im, .o_bin_last
);
